>>> rtl/cc_dec_pkg.sv
// ----------------------------------------------------------------------------
// cc_dec_pkg
// Types, constants and the letter lookup shared by the cheat code decoder.
// ----------------------------------------------------------------------------
package cc_dec_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_MAPPER_NUMBER = 8'd0;
  localparam logic [7:0] CFG_ROM_BANKS_8K  = 8'd1;

  // Mapper ids with a rule of their own
  localparam logic [7:0] MAPPER_FIXED_HIGH = 8'd2;
  localparam logic [7:0] MAPPER_CHR_BANKED = 8'd3;
  localparam logic [7:0] MAPPER_SPLIT_MMC  = 8'd4;
  localparam logic [7:0] MAPPER_BANKED_32K = 8'd66;
  localparam logic [7:0] MAPPER_SPLIT_8K   = 8'd40;

  // Register reset values
  localparam logic [7:0] MAPPER_RESET = 8'd0;
  localparam logic [7:0] BANKS_RESET  = 8'd4;

  // Code length limits
  localparam logic [3:0] LEN_SHORT = 4'd6;
  localparam logic [3:0] LEN_LONG  = 4'd8;
  localparam logic [3:0] LEN_SAT   = 4'd9;

  // Address constants
  localparam logic [15:0] ROM_BASE = 16'h8000;
  localparam logic [7:0]  BANKS_HALF = 8'd2;   // ROM size equal to 0x4000
  localparam int          OFF_W    = 23;       // signed offset width

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } cc_in_t;

  typedef struct packed {
    logic        code_ok;
    logic [15:0] decoded_address;
    logic [7:0]  patch_value;
    logic        uses_compare;
    logic [7:0]  compare_byte;
    logic [20:0] rom_offset;
    logic        offset_ok;
  } cc_out_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] nibble;
  } letter_code_t;

  // Map an upper case letter to its position in the code alphabet
  function automatic letter_code_t letter_lookup(input logic [7:0] ch);
    letter_code_t r;
    r.hit = 1'b1;
    unique case (ch)
      "A": r.nibble = 4'd0;
      "P": r.nibble = 4'd1;
      "Z": r.nibble = 4'd2;
      "L": r.nibble = 4'd3;
      "G": r.nibble = 4'd4;
      "I": r.nibble = 4'd5;
      "T": r.nibble = 4'd6;
      "Y": r.nibble = 4'd7;
      "E": r.nibble = 4'd8;
      "O": r.nibble = 4'd9;
      "X": r.nibble = 4'd10;
      "U": r.nibble = 4'd11;
      "K": r.nibble = 4'd12;
      "S": r.nibble = 4'd13;
      "V": r.nibble = 4'd14;
      "N": r.nibble = 4'd15;
      default: begin
        r.hit    = 1'b0;
        r.nibble = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cheat_code_decoder.sv
// ----------------------------------------------------------------------------
// cheat_code_decoder
// Collects cheat code letters one character per transfer and, on the last
// character, unscrambles address, value and compare byte and maps the
// address to a program ROM offset.
// ----------------------------------------------------------------------------
//
//  channel | ports                              | direction
//  --------+------------------------------------+----------------
//  input   | in_valid, in_stall, in_data        | characters in
//  result  | out_valid, out_stall, out_data     | decoded code out
//  config  | cfg_valid, cfg_ready, cfg_index,   | register writes
//          | cfg_data                           |
//
//  One character per cycle is taken, back to back, while in_stall is low;
//  the result of a code goes through the input register, then the result
//  register, before it is offered on out_valid.
//  Synchronous active-low reset clears the collected letters, both stages
//  and the registers (mapper 0, four 8 KB banks).
//  A stalled result holds its register; the input stage stalls only while
//  it holds a character and the result register cannot take a new entry.
//
module cheat_code_decoder
  import cc_dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  cc_in_t     in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output cc_out_t    out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]   mapper_number_r;
  logic [7:0]   rom_banks_8k_r;
  logic         in_valid_r;
  cc_in_t       in_data_r;
  logic         out_valid_r;
  cc_out_t      out_data_r;
  logic [3:0]   letter_nibbles_r [8];
  logic [3:0]   letter_nibbles_nxt [8];
  logic [3:0]   n_cur [8];
  logic [3:0]   letter_count_r, letter_count_nxt, count_cur;
  logic         bad_letter_r, bad_letter_nxt, bad_cur;
  logic         res_free, s1_go;
  logic [7:0]   upper;
  logic         is_letter;
  letter_code_t code;
  cc_out_t      res;
  logic         code_ok, eight;
  logic [14:0]  addr_low;
  logic [15:0]  addr;
  logic [20:0]  rom_size;
  logic signed [OFF_W-1:0] off, size_s, d_s, banks_s;

  // Handshake
  assign cfg_ready = 1'b1;
  assign res_free  = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !res_free;
  assign s1_go     = in_valid_r && res_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_number_r <= MAPPER_RESET;
      rom_banks_8k_r  <= BANKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAPPER_NUMBER) mapper_number_r <= cfg_data;
      if (cfg_index == CFG_ROM_BANKS_8K)  rom_banks_8k_r  <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Fold case and look the letter up
  always_comb begin
    upper = in_data_r.character;
    if (upper >= "a" && upper <= "z") upper = upper - 8'd32;
    is_letter = (upper >= "A") && (upper <= "Z");
    code      = letter_lookup(upper);
  end

  // Take the character into the letter store
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      n_cur[i] = letter_nibbles_r[i];
    end
    count_cur = letter_count_r;
    bad_cur   = bad_letter_r;
    if (is_letter) begin
      if (!code.hit) bad_cur = 1'b1;
      if (letter_count_r < LEN_LONG) n_cur[letter_count_r[2:0]] = code.nibble;
      if (letter_count_r < LEN_SAT) count_cur = letter_count_r + 4'd1;
    end
  end

  // Hold, advance, or clear after the last character
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      letter_nibbles_nxt[i] = letter_nibbles_r[i];
    end
    letter_count_nxt = letter_count_r;
    bad_letter_nxt   = bad_letter_r;
    if (s1_go) begin
      if (in_data_r.last) begin
        for (int i = 0; i < 8; i++) begin
          letter_nibbles_nxt[i] = 4'd0;
        end
        letter_count_nxt = 4'd0;
        bad_letter_nxt   = 1'b0;
      end else begin
        for (int i = 0; i < 8; i++) begin
          letter_nibbles_nxt[i] = n_cur[i];
        end
        letter_count_nxt = count_cur;
        bad_letter_nxt   = bad_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        letter_nibbles_r[i] <= 4'd0;
      end
      letter_count_r <= 4'd0;
      bad_letter_r   <= 1'b0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        letter_nibbles_r[i] <= letter_nibbles_nxt[i];
      end
      letter_count_r <= letter_count_nxt;
      bad_letter_r   <= bad_letter_nxt;
    end
  end

  // Unscramble address, value and compare byte
  assign code_ok = !bad_cur && (count_cur == LEN_SHORT || count_cur == LEN_LONG);
  assign eight   = (count_cur == LEN_LONG);
  assign addr_low = {n_cur[3][2:0], n_cur[4][3], n_cur[5][2:0], n_cur[1][3],
                     n_cur[2][2:0], n_cur[3][3], n_cur[4][2:0]};
  assign addr     = ROM_BASE | {1'b0, addr_low};

  // Map the address to a ROM offset
  assign rom_size = {rom_banks_8k_r, 13'd0};
  assign size_s   = OFF_W'(signed'({2'b00, rom_size}));
  assign d_s      = OFF_W'(signed'({8'd0, addr_low}));
  assign banks_s  = OFF_W'(signed'({15'd0, rom_banks_8k_r}));

  always_comb begin
    unique case (mapper_number_r) inside
      MAPPER_FIXED_HIGH: begin
        if (!addr[14]) off = d_s;
        else off = size_s - OFF_W'(24'sh4000) + OFF_W'(signed'({9'd0, addr[13:0]}));
      end
      MAPPER_CHR_BANKED, MAPPER_SPLIT_MMC, MAPPER_BANKED_32K: begin
        off = d_s;
      end
      MAPPER_SPLIT_8K: begin
        if (addr[14:13] == 2'b00) begin
          off = d_s;
        end else if (addr[14:13] == 2'b01) begin
          off = ((banks_s - OFF_W'(24'sd2)) <<< 13)
              + OFF_W'(signed'({10'd0, addr[12:0]}));
        end else begin
          off = ((banks_s - OFF_W'(24'sd1)) <<< 13)
              + OFF_W'(signed'({9'd0, addr[13:0]}));
        end
      end
      default: begin
        if (rom_banks_8k_r == BANKS_HALF) off = OFF_W'(signed'({9'd0, addr_low[13:0]}));
        else off = d_s;
      end
    endcase
  end

  // Assemble the result; a bad code leaves every other field zero
  always_comb begin
    res = '0;
    if (code_ok) begin
      res.code_ok         = 1'b1;
      res.decoded_address = addr;
      res.patch_value     = {n_cur[0][3], n_cur[1][2:0],
                             (eight ? n_cur[7][3] : n_cur[5][3]), n_cur[0][2:0]};
      res.uses_compare    = eight;
      if (eight) begin
        res.compare_byte = {n_cur[6][3], n_cur[7][2:0], n_cur[5][3], n_cur[6][2:0]};
      end
      res.rom_offset = off[20:0];
      res.offset_ok  = (off >= 0) && (off < size_s);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= s1_go && in_data_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && in_data_r.last) begin
      out_data_r <= res;
    end
  end

endmodule
